>>> src/ultrasonic_echo_median_ranger_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the echo median ranger
// Implication checks that reference clk and rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_MEDIAN_RANGER_TOP_MACROS_SVH
`define ULTRASONIC_ECHO_MEDIAN_RANGER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define UEMR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define UEMR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define UEMR_ASSERT_IMP(lbl, ante, cons)
`define UEMR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> src/uemr_pkg.sv
// ----------------------------------------------------------------------------
// uemr_pkg
// Shared types and constants of the echo median ranger.
// ----------------------------------------------------------------------------
package uemr_pkg;

    localparam int ACT_W       = 2;
    localparam int TS_W        = 32;
    localparam int DIST_W      = 16;
    localparam int WINDOW_DEF  = 5;

    // widths at or above this saturate the distance (65536 * 58 / 16)
    localparam logic [TS_W-1:0] SAT_WIDTH = 32'd237568;

    // floor(x / 29) = (x * RECIP) >> RECIP_SHIFT for x < 2^21
    localparam int X_W         = 21;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 22'd2314099;

    typedef enum logic [ACT_W-1:0] {
        ACT_FALL    = 2'd0,
        ACT_RISE    = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SHIFT,
        ST_RANK,
        ST_OUT
    } state_t;

    // per-cycle commands to every cell
    typedef struct packed {
        logic shift;
        logic rank_clr;
        logic rank_en;
    } cell_ctl_t;

    // entry broadcast to all cells during ranking
    typedef struct packed {
        logic              pos;
        logic [DIST_W-1:0] distance;
    } bcast_t;

endpackage

>>> src/uemr_conv.sv
// ----------------------------------------------------------------------------
// uemr_conv
// Pulse width to distance in 1/16 cm: floor(width * 8 / 29), saturated.
// ----------------------------------------------------------------------------
module uemr_conv (
    input  logic                         clk,
    input  logic                         load,
    input  logic [uemr_pkg::TS_W-1:0]    width,
    output logic [uemr_pkg::DIST_W-1:0]  distance
);
    import uemr_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              sat_reg;
    logic [X_W-1:0]    x;

    // scale by 8; only the low bits matter when not saturating
    assign x = {width[X_W-4:0], 3'b000};

    // register the reciprocal product and the saturation flag
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(x) * PROD_W'(RECIP);
            sat_reg  <= (width >= SAT_WIDTH);
        end
    end

    // pick the quotient bits
    assign distance = sat_reg ? {DIST_W{1'b1}} : prod_reg[RECIP_SHIFT +: DIST_W];

endmodule

>>> src/uemr_cell.sv
// ----------------------------------------------------------------------------
// uemr_cell
// One window entry: shifts from its neighbor and counts its own rank
// among the positive entries as they are broadcast.
// ----------------------------------------------------------------------------
module uemr_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 3,
    parameter int K_W   = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  uemr_pkg::cell_ctl_t          ctl,
    input  logic                         prev_valid,
    input  logic [uemr_pkg::DIST_W-1:0]  prev_dist,
    input  uemr_pkg::bcast_t             bc,
    input  logic [CNT_W-1:0]             bc_idx,
    output logic                         valid,
    output logic [uemr_pkg::DIST_W-1:0]  distance,
    output logic [K_W-1:0]               rank
);
    import uemr_pkg::*;

    logic              valid_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [K_W-1:0]    rank_reg;
    logic [K_W-1:0]    rank_next;
    logic              ahead;

    // advance the valid bit along the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            if (ctl.shift)
            begin
                valid_reg <= prev_valid;
            end
            rank_reg <= rank_next;
        end
    end

    // advance the distance along the chain
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            dist_reg <= prev_dist;
        end
    end

    // broadcast entry sorts ahead of this one: smaller, or equal and lower (newer) index
    always_comb
    begin
        ahead = bc.pos && ((bc.distance < dist_reg) ||
                           ((bc.distance == dist_reg) && (bc_idx < CNT_W'(IDX))));
        rank_next = rank_reg;
        if (ctl.rank_clr)
        begin
            rank_next = '0;
        end
        else if (ctl.rank_en && ahead)
        begin
            rank_next = rank_reg + K_W'(1);
        end
    end

    assign valid    = valid_reg;
    assign distance = dist_reg;
    assign rank     = rank_reg;

endmodule

>>> src/ultrasonic_echo_median_ranger_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_median_ranger_top
// Echo pulse ranging with an upper-median filter over the last WINDOW entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one echo word: action and
//   timestamp_us. A rising edge is absorbed in the accepting cycle and gives
//   no result. A falling edge or timeout gives at most one result word on the
//   output channel (out_valid/out_ready): median_distance and no_echo.
//   Sequence: a falling edge or timeout passes from accept to result valid
//   through the multiply state, the shift state, the rank state in which each
//   window entry is broadcast once to the cell chain, and the output state.
//   The next word is taken once the block is back in idle; a rising edge or
//   an unused code is absorbed in idle. No new echo word is accepted until
//   the current one has left the output state.
//   Reset: clears the window to all invalid, drops the stored start and any
//   pending result.
//   Stall: a finished result waits in the output register while the next word
//   is accepted and processed; that next word's result waits in the output
//   cycle until the register frees.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_median_ranger_top_macros.svh"

module ultrasonic_echo_median_ranger_top #(
    parameter int WINDOW = uemr_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [uemr_pkg::ACT_W-1:0]    action,
    input  logic [uemr_pkg::TS_W-1:0]     timestamp_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [uemr_pkg::DIST_W-1:0]   median_distance,
    output logic                          no_echo
);
    import uemr_pkg::*;

    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int K_W   = $clog2(WINDOW + 1);

    state_t            state_reg, state_next;
    logic [TS_W-1:0]   start_reg, start_next;
    logic              start_present_reg, start_present_next;
    logic [TS_W-1:0]   width_reg, width_next;
    logic              entry_valid_reg, entry_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              any_valid_reg, any_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] median_reg, median_next;
    logic              no_echo_reg, no_echo_next;

    logic              accept;
    logic              slot_free;
    logic              conv_load;
    logic [DIST_W-1:0] conv_dist;
    cell_ctl_t         ctl;
    bcast_t            bc;
    logic [DIST_W-1:0] pick;

    logic              cell_valid [WINDOW];
    logic [DIST_W-1:0] cell_dist  [WINDOW];
    logic [K_W-1:0]    cell_rank  [WINDOW];
    logic [WINDOW-1:0] cell_pos;
    logic [WINDOW-1:0] hit;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // distance conversion unit
    uemr_conv u_conv (
        .clk      (clk),
        .load     (conv_load),
        .width    (width_reg),
        .distance (conv_dist)
    );

    // chain of window cells, cell 0 takes the new entry
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            logic              pv;
            logic [DIST_W-1:0] pd;
            if (gi == 0)
            begin : g_head
                assign pv = entry_valid_reg;
                assign pd = conv_dist;
            end
            else
            begin : g_link
                assign pv = cell_valid[gi-1];
                assign pd = cell_dist[gi-1];
            end
            uemr_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W),
                .K_W   (K_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_valid (pv),
                .prev_dist  (pd),
                .bc         (bc),
                .bc_idx     (cnt_reg),
                .valid      (cell_valid[gi]),
                .distance   (cell_dist[gi]),
                .rank       (cell_rank[gi])
            );
            assign cell_pos[gi] = cell_valid[gi] && (cell_dist[gi] != '0);
            assign hit[gi]      = cell_pos[gi] && (cell_rank[gi] == (k_reg >> 1));
        end
    endgenerate

    // broadcast the entry selected by the rank counter
    always_comb
    begin
        bc.pos      = cell_pos[cnt_reg];
        bc.distance = cell_dist[cnt_reg];
    end

    // select the median entry
    always_comb
    begin
        pick = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            pick = pick | (cell_dist[i] & {DIST_W{hit[i]}});
        end
    end

    // hold state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            start_reg         <= '0;
            start_present_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
            k_reg             <= '0;
            any_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            start_reg         <= start_next;
            start_present_reg <= start_present_next;
            out_valid_reg     <= out_valid_next;
            cnt_reg           <= cnt_next;
            k_reg             <= k_next;
            any_valid_reg     <= any_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg       <= width_next;
        entry_valid_reg <= entry_valid_next;
        median_reg      <= median_next;
        no_echo_reg     <= no_echo_next;
    end

    // sequence one echo word through multiply, shift, rank and output
    always_comb
    begin
        state_next         = state_reg;
        start_next         = start_reg;
        start_present_next = start_present_reg;
        width_next         = width_reg;
        entry_valid_next   = entry_valid_reg;
        cnt_next           = cnt_reg;
        k_next             = k_reg;
        any_valid_next     = any_valid_reg;
        median_next        = median_reg;
        no_echo_next       = no_echo_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        in_ready           = 1'b0;
        conv_load          = 1'b0;
        ctl                = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_RISE:
                        begin
                            start_next         = timestamp_us;
                            start_present_next = 1'b1;
                        end
                        ACT_FALL:
                        begin
                            width_next       = start_present_reg ?
                                               (timestamp_us - start_reg) : '0;
                            entry_valid_next = start_present_reg;
                            state_next       = ST_MUL;
                        end
                        ACT_TIMEOUT:
                        begin
                            width_next         = '0;
                            entry_valid_next   = 1'b1;
                            start_present_next = 1'b0;
                            state_next         = ST_MUL;
                        end
                        default:
                        begin
                            // unused code: drop the word
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                conv_load  = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctl.shift      = 1'b1;
                ctl.rank_clr   = 1'b1;
                cnt_next       = '0;
                k_next         = '0;
                any_valid_next = 1'b0;
                state_next     = ST_RANK;
            end
            ST_RANK:
            begin
                ctl.rank_en    = 1'b1;
                k_next         = k_reg + K_W'(bc.pos);
                any_valid_next = any_valid_reg || cell_valid[cnt_reg];
                if (cnt_reg == CNT_W'(WINDOW - 1))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    if (any_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        median_next    = (k_reg == '0) ? '0 : pick;
                        no_echo_next   = (k_reg == '0);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign median_distance = median_reg;
    assign no_echo         = no_echo_reg;

    // no-echo results carry a zero distance
    `UEMR_ASSERT_IMP(a_no_echo_zero, out_valid && no_echo, median_distance == '0)
    // exactly one cell holds the median rank when positives exist
    `UEMR_ASSERT_IMP(a_one_median, (state_reg == ST_OUT) && (k_reg != '0), $onehot(hit))
    // a result is loaded when the slot frees with valid entries present
    `UEMR_ASSERT_NXT(a_result_load, (state_reg == ST_OUT) && slot_free && any_valid_reg,
                     out_valid_reg)

endmodule

>>> tb/sv/ultrasonic_echo_median_ranger_checker.sv
// ----------------------------------------------------------------------------
// Echo median ranger checker
// Watches both channels of the ranger, predicts the range word for every
// accepted echo word and compares each delivered word field by field.
// ----------------------------------------------------------------------------
module ultrasonic_echo_median_ranger_checker #(
    parameter int WINDOW = uemr_pkg::WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [uemr_pkg::ACT_W-1:0]    action,
    input  logic [uemr_pkg::TS_W-1:0]     timestamp_us,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [uemr_pkg::DIST_W-1:0]   median_distance,
    input  logic                          no_echo,
    output int                            fail_count,
    output int                            pending_count,
    output int                            ranges_checked,
    output int                            no_echo_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import uemr_pkg::*;

    // pulse width to 1/16 cm: width * 16 / 58
    localparam logic [63:0]       SCALE_NUM = 64'd16;
    localparam logic [63:0]       SCALE_DEN = 64'd58;
    localparam logic [DIST_W-1:0] DIST_SAT  = '1;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              no_echo_flag;
    } range_word_t;

    // predicted ranger state
    logic [DIST_W-1:0] win_dist  [WINDOW];
    logic              win_valid [WINDOW];
    logic [TS_W-1:0]   start_ts;
    logic              start_held;

    range_word_t expected_ranges [$];

    int faults  = 0;
    int pending = 0;
    int checked = 0;
    int silent  = 0;

    assign fail_count     = faults;
    assign pending_count  = pending;
    assign ranges_checked = checked;
    assign no_echo_count  = silent;

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("RANGE MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        faults++;
    endtask

    function automatic void clear_ranger();
        for (int i = 0; i < WINDOW; i++) begin
            win_dist[i]  = '0;
            win_valid[i] = 1'b0;
        end
        start_ts   = '0;
        start_held = 1'b0;
    endfunction

    function automatic logic [DIST_W-1:0] pulse_to_distance(input logic [TS_W-1:0] width);
        logic [63:0] scaled;
        scaled = (64'(width) * SCALE_NUM) / SCALE_DEN;
        return (scaled > 64'(DIST_SAT)) ? DIST_SAT : scaled[DIST_W-1:0];
    endfunction

    // drop the oldest entry, insert the new one at the front
    function automatic void push_entry(input logic valid, input logic [DIST_W-1:0] distance);
        for (int i = WINDOW - 1; i > 0; i--) begin
            win_dist[i]  = win_dist[i-1];
            win_valid[i] = win_valid[i-1];
        end
        win_dist[0]  = distance;
        win_valid[0] = valid;
    endfunction

    // upper median of the positive valid entries; 0 when nothing is valid
    function automatic bit upper_median(output range_word_t word);
        logic [DIST_W-1:0] ranked [WINDOW];
        logic [DIST_W-1:0] v;
        int                k;
        int                j;
        bit                any_valid;
        k         = 0;
        any_valid = 1'b0;
        word      = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (win_valid[i]) begin
                any_valid = 1'b1;
                if (win_dist[i] != '0) begin
                    v = win_dist[i];
                    j = k;
                    while (j > 0 && ranked[j-1] > v) begin
                        ranked[j] = ranked[j-1];
                        j--;
                    end
                    ranked[j] = v;
                    k++;
                end
            end
        end
        if (k == 0)
            word.no_echo_flag = 1'b1;
        else
            word.distance = ranked[k/2];
        return any_valid;
    endfunction

    // advance the predicted state by one echo word; 1 when a range word follows
    function automatic bit predict_echo(input logic [ACT_W-1:0] act, input logic [TS_W-1:0] ts,
                                        output range_word_t word);
        word = '0;
        case (act)
            ACT_RISE:
            begin
                start_ts   = ts;
                start_held = 1'b1;
                return 1'b0;
            end
            ACT_FALL:
            begin
                if (start_held)
                    push_entry(1'b1, pulse_to_distance(ts - start_ts));
                else
                    push_entry(1'b0, '0);
            end
            ACT_TIMEOUT:
            begin
                push_entry(1'b1, '0);
                start_held = 1'b0;
            end
            default:
                return 1'b0;
        endcase
        return upper_median(word);
    endfunction

    initial
    begin
        clear_ranger();
    end

    // compare delivered words first, then queue the prediction for a new echo word
    always @(posedge clk or negedge rst_n)
    begin : watch
        range_word_t want;
        range_word_t seen;
        if (!rst_n)
        begin
            clear_ranger();
            expected_ranges.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen.distance     = median_distance;
                seen.no_echo_flag = no_echo;
                checked++;
                if (no_echo)
                    silent++;
                if (expected_ranges.size() == 0)
                    report("range word with nothing pending, median_distance", 0, seen.distance);
                else
                begin
                    want = expected_ranges.pop_front();
                    if (seen.distance !== want.distance)
                        report("median_distance", want.distance, seen.distance);
                    if (seen.no_echo_flag !== want.no_echo_flag)
                        report("no_echo", want.no_echo_flag, seen.no_echo_flag);
                end
            end
            if (in_valid && in_ready)
            begin
                if (predict_echo(action, timestamp_us, want))
                    expected_ranges.push_back(want);
            end
        end
        pending = expected_ranges.size();
    end

endmodule

>>> tb/sv/ultrasonic_echo_median_ranger_top_tb.sv
// ----------------------------------------------------------------------------
// Echo median ranger testbench
// Drives echo words (rise, fall, timeout, unused code) into the ranger with
// random idling on both channels and one long output hold-off, while the
// checker predicts and compares every range word.
// ----------------------------------------------------------------------------
module ultrasonic_echo_median_ranger_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uemr_pkg::*;

    localparam int WINDOW = WINDOW_DEF;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int TOTAL_WORDS = 875;
    localparam int IDLE_PCT    = 17;
    localparam int QUIET_FROM  = 400;
    localparam int QUIET_TO    = 560;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 4 * (WINDOW + 4);
    localparam int CYCLE_LIMIT = 200000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic [ACT_W-1:0]  action       = '0;
    logic [TS_W-1:0]   timestamp_us = '0;
    logic              out_ready    = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [DIST_W-1:0] median_distance;
    logic              no_echo;

    int  ranger_faults;
    int  ranger_pending;
    int  ranges_checked;
    int  no_echo_count;
    int  words_sent  = 0;
    int  echo_words  = 0;
    int  cycle_count = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    logic quiet;

    assign quiet = (echo_words >= QUIET_FROM) && (echo_words < QUIET_TO);

    ultrasonic_echo_median_ranger_top #(
        .WINDOW (WINDOW)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .timestamp_us    (timestamp_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .median_distance (median_distance),
        .no_echo         (no_echo)
    );

    ultrasonic_echo_median_ranger_checker #(
        .WINDOW (WINDOW)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .timestamp_us    (timestamp_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .median_distance (median_distance),
        .no_echo         (no_echo),
        .fail_count      (ranger_faults),
        .pending_count   (ranger_pending),
        .ranges_checked  (ranges_checked),
        .no_echo_count   (no_echo_count)
    );

    always #5 clk = ~clk;

    // end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && echo_words >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // offer one word and hold it until taken, then maybe idle before the next
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [TS_W-1:0] ts);
        in_valid     <= 1'b1;
        action       <= act;
        timestamp_us <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (act != ACT_UNUSED)
            echo_words++;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // pulse widths: under one centimetre, typical, long, around saturation, anything
    function automatic logic [TS_W-1:0] pick_width();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return $urandom_range(0, 57);
        else if (sel < 55)
            return $urandom_range(58, 20000);
        else if (sel < 72)
            return $urandom_range(20000, 237567);
        else if (sel < 85)
            return $urandom_range(237560, 237580);
        else
            return $urandom();
    endfunction

    // start times, some just below the wrap point
    function automatic logic [TS_W-1:0] pick_start();
        if ($urandom_range(0, 4) == 0)
            return 32'hFFFF_FFFF - $urandom_range(0, 2000);
        return $urandom();
    endfunction

    initial
    begin : stimulus
        logic [TS_W-1:0] start;
        int              pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fall with no start into an empty window, unused code, lone timeout
        send_word(ACT_FALL, 32'd5);
        send_word(ACT_UNUSED, 32'hFFFF_FFFF);
        send_word(ACT_TIMEOUT, 32'd0);
        // zero width, sub-unit width, exact units, repeated falls from one start
        send_word(ACT_RISE, 32'd0);
        send_word(ACT_FALL, 32'd0);
        send_word(ACT_FALL, 32'd57);
        send_word(ACT_RISE, 32'd1000);
        send_word(ACT_FALL, 32'd1058);
        send_word(ACT_FALL, 32'd6800);
        // width across the timestamp wrap
        send_word(ACT_RISE, 32'hFFFF_FFC0);
        send_word(ACT_FALL, 32'h0000_0010);
        // saturation edge and the largest width
        send_word(ACT_RISE, 32'd0);
        send_word(ACT_FALL, SAT_WIDTH - 32'd1);
        send_word(ACT_FALL, SAT_WIDTH);
        send_word(ACT_FALL, 32'hFFFF_FFFF);
        // timeout clears the start, so the next fall is an invalid entry
        send_word(ACT_TIMEOUT, 32'd300);
        send_word(ACT_FALL, 32'd500);
        send_word(ACT_RISE, 32'hFFFF_FFFF);
        send_word(ACT_FALL, 32'h0000_0121);
        send_word(ACT_FALL, 32'd2899);
        // flush the window with zeros
        repeat (5) send_word(ACT_TIMEOUT, 32'hAAAA_5555);

        // mostly well-formed rise/fall sequences, the rest noise
        while (echo_words < TOTAL_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                start = pick_start();
                send_word(ACT_RISE, start);
                repeat ($urandom_range(1, 3)) send_word(ACT_FALL, start + pick_width());
                if ($urandom_range(0, 4) == 0)
                    send_word(ACT_TIMEOUT, start + pick_width());
            end
            else if (pick < 80)
                send_word(ACT_TIMEOUT, $urandom());
            else if (pick < 90)
                send_word(ACT_FALL, $urandom());
            else if (pick < 96)
                send_word(ACT_RISE, $urandom());
            else
                send_word(ACT_UNUSED, $urandom());
        end
        in_valid <= 1'b0;

        // drain outstanding range words, then watch for strays
        while (ranger_pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Ranger run: %0d words accepted (%0d echo events), %0d range words checked",
                 words_sent, echo_words, ranges_checked);
        $display("  %0d no-echo results, window %0d, output held off %0d cycles once",
                 no_echo_count, WINDOW, HOLD_CYCLES);
        if (ranger_faults == 0 && ranger_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
